### src/wtlm_pkg.sv
`timescale 1ns / 1ps
package wtlm_pkg;

    localparam int TS_W    = 48;
    localparam int BYTES_W = 16;
    localparam int LAT_W   = 49;
    localparam int TOT_W   = 48;
    localparam int CFG_W   = 11;
    localparam int ENT_W   = 11;
    localparam int SCALE_W = 23;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 208;
    localparam int OUT_USER_W = 2;

    localparam logic [SCALE_W-1:0] TPUT_SCALE   = 23'd8000000;
    localparam logic [CFG_W-1:0]   CFG_RESET    = 11'd1000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_SRD,
        S_SPAN,
        S_MUL,
        S_DIVST,
        S_DIV
    } t_state;

endpackage

### src/window_throughput_latency_monitor.sv
`timescale 1ns / 1ps
// Channel   Direction  tdata                               tuser
// s_axis    in         send_time, recv_time, byte_count    is_bbr
// m_axis    out        totals, entries, tput, latency      last_bbr, span_invalid
// cfg       in         max_records (write only)            -
//
// A transaction passes through these steps before the next one is accepted: acceptance, the
// window update and the oldest-record read, the serial constant multiply, the start of the
// dividers, and the wait while the 60-bit latency divider runs.
// Reset is synchronous and clears the control state; the record store is not cleared.
// A finished result waits in the output register while the next transaction is taken,
// but the next result is held back until that register is free.
module window_throughput_latency_monitor
    import wtlm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // send_time, recv_time, byte_count
    input  logic [0:0]            i_s_tuser,   // is_bbr
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // total_bytes, total_count,
                                               // window_entries, avg_tput_kbps,
                                               // avg_latency_ns, zero fill
    output logic [OUT_USER_W-1:0] o_m_tuser,   // last_bbr, span_invalid
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int LIMW = (CW > CFG_W) ? CW : CFG_W;
    localparam int BW   = BYTES_W + CW;
    localparam int LW   = LAT_W + CW;
    localparam int PW   = BW + SCALE_W;
    localparam int QXW  = (PW > TOT_W) ? PW : TOT_W + 1;
    localparam int MBW  = $clog2(SCALE_W);

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_max;
    logic [TS_W-1:0]    r_snd, r_rcv;
    logic [BYTES_W-1:0] r_bytes;
    logic               r_in_bbr;

    logic [AW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [BW-1:0]      r_bsum;
    logic [LW-1:0]      r_lsum;
    logic [TS_W-1:0]    r_newest;
    logic [TOT_W-1:0]   r_btot, r_ptot;
    logic               r_bbr;

    logic [PW-1:0]      r_acc;
    logic [MBW-1:0]     r_mbit;
    logic [TS_W-1:0]    r_span;
    logic               r_span_pos;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [OUT_USER_W-1:0] r_m_user;

    logic [TS_W-1:0]    w_rd_send;
    logic [LAT_W-1:0]   w_rd_lat;
    logic [BYTES_W-1:0] w_rd_size;

    logic               w_accept, w_we, w_div_start, w_out_free, w_div_busy;
    logic               w_tbusy, w_lbusy;
    logic [LIMW-1:0]    w_cfg_ext, w_limit;
    logic               w_full, w_keep, w_drop;
    logic [CW:0]        w_slot_sum;
    logic [AW-1:0]      w_slot, w_head_inc;
    logic [LAT_W-1:0]   w_lat;
    logic [TOT_W:0]     w_btot_sum;
    logic [TS_W:0]      w_span;
    logic [LW-1:0]      w_lmag;
    logic [PW-1:0]      w_tq;
    logic [LW-1:0]      w_lq, w_lq_signed;
    logic [QXW-1:0]     w_tq_ext;
    logic [TOT_W-1:0]   w_tput;
    logic [LAT_W-1:0]   w_avg_lat;
    logic               w_invalid;

    // Window bookkeeping.
    assign w_cfg_ext  = LIMW'(r_max);
    assign w_limit    = (w_cfg_ext > LIMW'(WINDOW_DEPTH)) ? LIMW'(WINDOW_DEPTH) : w_cfg_ext;
    assign w_full     = LIMW'(r_count) >= w_limit;
    assign w_drop     = w_full && (r_count != '0);
    assign w_keep     = !w_full || (r_count != '0);
    assign w_slot_sum = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign w_slot     = (w_slot_sum >= (CW + 1)'(WINDOW_DEPTH))
                      ? AW'(w_slot_sum - (CW + 1)'(WINDOW_DEPTH)) : AW'(w_slot_sum);
    assign w_head_inc = (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_lat      = {1'b0, r_rcv} - {1'b0, r_snd};
    assign w_btot_sum = {1'b0, r_btot} + (TOT_W + 1)'(r_bytes);
    assign w_span     = {1'b0, r_newest} - {1'b0, w_rd_send};
    assign w_lmag     = r_lsum[LW-1] ? (~r_lsum + 1'b1) : r_lsum;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_div_busy = w_tbusy || w_lbusy;

    wtlm_store #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_send  (r_snd),
        .i_lat   (w_lat),
        .i_size  (r_bytes),
        .i_raddr (r_head),
        .o_send  (w_rd_send),
        .o_lat   (w_rd_lat),
        .o_size  (w_rd_size)
    );

    wtlm_div #(.NW(PW), .DW(TS_W)) u_tput_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_acc),
        .i_den   (r_span),
        .o_busy  (w_tbusy),
        .o_quot  (w_tq)
    );

    wtlm_div #(.NW(LW), .DW(CW)) u_lat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_lmag),
        .i_den   (r_count),
        .o_busy  (w_lbusy),
        .o_quot  (w_lq)
    );

    assign w_tq_ext    = QXW'(w_tq);
    assign w_tput      = (|w_tq_ext[QXW-1:TOT_W]) ? '1 : w_tq_ext[TOT_W-1:0];
    assign w_lq_signed = r_lsum[LW-1] ? (~w_lq + 1'b1) : w_lq;
    assign w_invalid   = (r_count == '0) || !r_span_pos;
    assign w_avg_lat   = (r_count == '0) ? '0 : w_lq_signed[LAT_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_tvalid) n_state = S_UPD;
            S_UPD:   n_state = S_SRD;
            S_SRD:   n_state = S_SPAN;
            S_SPAN:  n_state = S_MUL;
            S_MUL:   if (r_mbit == '0) n_state = S_DIVST;
            S_DIVST: n_state = S_DIV;
            S_DIV:   if (!w_div_busy && w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready  = 1'b0;
        w_we        = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_tready  = 1'b1;
            S_UPD:   w_we        = (r_bytes != '0) && w_keep;
            S_DIVST: w_div_start = 1'b1;
            default: ;
        endcase
    end

    assign w_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max     <= CFG_RESET;
            r_head    <= '0;
            r_count   <= '0;
            r_bsum    <= '0;
            r_lsum    <= '0;
            r_newest  <= '0;
            r_btot    <= '0;
            r_ptot    <= '0;
            r_bbr     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (r_state == S_UPD && r_bytes != '0) begin
                r_btot <= w_btot_sum[TOT_W] ? '1 : w_btot_sum[TOT_W-1:0];
                if (r_ptot != '1) begin
                    r_ptot <= r_ptot + 1'b1;
                end
                r_bbr <= r_in_bbr;
                r_bsum <= r_bsum - (w_drop ? BW'(w_rd_size) : '0)
                                 + (w_keep ? BW'(r_bytes) : '0);
                r_lsum <= r_lsum - (w_drop ? {{CW{w_rd_lat[LAT_W-1]}}, w_rd_lat} : '0)
                                 + (w_keep ? {{CW{w_lat[LAT_W-1]}}, w_lat} : '0);
                if (w_keep) begin
                    r_newest <= r_rcv;
                end
                if (w_drop) begin
                    r_head <= w_head_inc;
                end
                if (w_keep && !w_drop) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (r_state == S_DIV && !w_div_busy && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_snd    <= i_s_tdata[TS_W-1:0];
            r_rcv    <= i_s_tdata[2*TS_W-1:TS_W];
            r_bytes  <= i_s_tdata[2*TS_W+BYTES_W-1:2*TS_W];
            r_in_bbr <= i_s_tuser[0];
        end
        if (r_state == S_SPAN) begin
            r_span     <= w_span[TS_W-1:0];
            r_span_pos <= !w_span[TS_W] && (w_span != '0);
            r_acc      <= '0;
            r_mbit     <= MBW'(SCALE_W - 1);
        end
        if (r_state == S_MUL) begin
            r_acc  <= {r_acc[PW-2:0], 1'b0} + (TPUT_SCALE[r_mbit] ? PW'(r_bsum) : '0);
            r_mbit <= r_mbit - 1'b1;
        end
        if (r_state == S_DIV && !w_div_busy && w_out_free) begin
            r_m_data <= {4'b0, w_avg_lat, (w_invalid ? {TOT_W{1'b0}} : w_tput),
                         ENT_W'(r_count), r_ptot, r_btot};
            r_m_user <= {w_invalid, r_bbr};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(WINDOW_DEPTH))
        else $error("window count exceeds depth");

    a_empty_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_bsum == '0 && r_lsum == '0))
        else $error("empty window holds non-zero sums");

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_busy)
        else $error("divider busy while idle");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW + 1)'(r_head) < (AW + 1)'(WINDOW_DEPTH))
        else $error("head index out of range");
`endif

endmodule

### src/wtlm_store.sv
`timescale 1ns / 1ps
module wtlm_store
    import wtlm_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic [TS_W-1:0]     i_send,
    input  logic [LAT_W-1:0]    i_lat,
    input  logic [BYTES_W-1:0]  i_size,
    input  logic [AW-1:0]       i_raddr,
    output logic [TS_W-1:0]     o_send,
    output logic [LAT_W-1:0]    o_lat,
    output logic [BYTES_W-1:0]  o_size
);

    logic [TS_W-1:0]    r_send_mem [DEPTH];
    logic [LAT_W-1:0]   r_lat_mem  [DEPTH];
    logic [BYTES_W-1:0] r_size_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_send_mem[i_waddr] <= i_send;
            r_lat_mem[i_waddr]  <= i_lat;
            r_size_mem[i_waddr] <= i_size;
        end
        o_send <= r_send_mem[i_raddr];
        o_lat  <= r_lat_mem[i_raddr];
        o_size <= r_size_mem[i_raddr];
    end

endmodule

### src/wtlm_div.sv
`timescale 1ns / 1ps
module wtlm_div #(
    parameter int NW = 50,
    parameter int DW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_den;
    logic [DW-1:0]   r_rem;
    logic [DW:0]     w_trial;
    logic [DW:0]     w_diff;
    logic            w_ge;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_num <= {r_num[NW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule
